// ===== rtl/sdc_pkg.sv =====
// Package for the settable digital clock: request and display types,
// key codes, cursor positions and digit limits. No dependencies.
package sdc_pkg;

   // Kind of a request.
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_KEY  = 1'b1;

   // Raw active-low key bytes.
   localparam logic [7:0] KEY_DOWN  = 8'hfe;
   localparam logic [7:0] KEY_UP    = 8'hfd;
   localparam logic [7:0] KEY_RIGHT = 8'hfb;
   localparam logic [7:0] KEY_LEFT  = 8'hf7;
   localparam logic [7:0] KEY_MODE  = 8'hef;

   // Cursor positions, from left to right on the display.
   localparam logic [2:0] CURSOR_HOUR_TENS     = 3'd0;
   localparam logic [2:0] CURSOR_HOUR_UNITS    = 3'd1;
   localparam logic [2:0] CURSOR_MINUTE_TENS   = 3'd2;
   localparam logic [2:0] CURSOR_MINUTE_UNITS  = 3'd3;
   localparam logic [2:0] CURSOR_SECOND_TENS   = 3'd4;
   localparam logic [2:0] CURSOR_SECOND_UNITS  = 3'd5;

   // Digit limits.
   localparam logic [3:0] UNITS_MAX       = 4'd9;
   localparam logic [2:0] SIXTY_TENS_MAX  = 3'd5;
   localparam logic [1:0] HOUR_TENS_MAX   = 2'd2;
   localparam logic [3:0] HOUR_UNITS_WRAP = 4'd4;
   localparam logic [1:0] HOUR_TENS_LAST  = 2'd2;
   localparam logic [3:0] HOUR_UNITS_LAST = 4'd3;

   // Reset value of the ticks-per-second register.
   localparam logic [7:0] TPS_RESET = 8'd16;

   typedef struct packed {
      logic       kind;
      logic [7:0] key_code;
   } request_type;

   typedef struct packed {
      logic [1:0] hour_tens;
      logic [3:0] hour_units;
      logic [2:0] minute_tens;
      logic [3:0] minute_units;
      logic [2:0] second_tens;
      logic [3:0] second_units;
      logic       editing;
      logic [2:0] cursor;
   } display_type;

   typedef struct packed {
      logic [7:0]  prescale;
      display_type disp;
   } clock_state_type;

endpackage

// ===== rtl/sdc_req_if.sv =====
// Request channel of the settable digital clock: valid/ready handshake
// with a tick-or-key payload. Stands alone.
interface sdc_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] key_code;

   modport source (output valid, output kind, output key_code, input ready);
   modport sink   (input valid, input kind, input key_code, output ready);
endinterface

// ===== rtl/sdc_rsp_if.sv =====
// Response channel of the settable digital clock: valid/ready handshake
// carrying six BCD digits, edit mode and cursor. Stands alone.
interface sdc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] hour_tens;
   logic [3:0] hour_units;
   logic [2:0] minute_tens;
   logic [3:0] minute_units;
   logic [2:0] second_tens;
   logic [3:0] second_units;
   logic       edit_mode;
   logic [2:0] cursor;

   modport source (output valid, output hour_tens, output hour_units,
                   output minute_tens, output minute_units, output second_tens,
                   output second_units, output edit_mode, output cursor,
                   input ready);
   modport sink   (input valid, input hour_tens, input hour_units,
                   input minute_tens, input minute_units, input second_tens,
                   input second_units, input edit_mode, input cursor,
                   output ready);
endinterface

// ===== rtl/sdc_step.sv =====
// Next-state logic of the settable digital clock: prescaler, BCD time
// carry chain and digit editor. Depends on sdc_pkg.
module sdc_step (
   input  sdc_pkg::clock_state_type state_cur,
   input  sdc_pkg::request_type     req_item,
   input  logic [7:0]               ticks_per_second,
   output sdc_pkg::clock_state_type state_nxt
);
   import sdc_pkg::*;

   function automatic logic [3:0] units_step(input logic [3:0] u, input logic raise);
      if (raise) begin
         return (u == UNITS_MAX) ? 4'd0 : u + 4'd1;
      end
      return (u == 4'd0) ? UNITS_MAX : u - 4'd1;
   endfunction

   function automatic logic [2:0] tens_step(input logic [2:0] t, input logic [2:0] top,
                                            input logic raise);
      if (raise) begin
         return (t == top) ? 3'd0 : t + 3'd1;
      end
      return (t == 3'd0) ? top : t - 3'd1;
   endfunction

   logic [7:0]  prescale_inc;
   logic        second_tick;
   logic        raise;
   logic        edit_en;
   display_type d;

   always_comb begin
      state_nxt    = state_cur;
      d            = state_cur.disp;
      prescale_inc = state_cur.prescale + 8'd1;
      second_tick  = 1'b0;
      raise        = 1'b0;
      edit_en      = 1'b0;

      if (req_item.kind == KIND_TICK) begin
         if (prescale_inc >= ticks_per_second) begin
            state_nxt.prescale = 8'd0;
            second_tick        = 1'b1;
         end else begin
            state_nxt.prescale = prescale_inc;
         end
      end else if (req_item.key_code == KEY_MODE) begin
         d.editing = ~d.editing;
      end else if (d.editing) begin
         case (req_item.key_code)
            KEY_DOWN: begin
               edit_en = 1'b1;
            end
            KEY_UP: begin
               edit_en = 1'b1;
               raise   = 1'b1;
            end
            KEY_RIGHT: begin
               if (d.cursor < CURSOR_SECOND_UNITS) d.cursor = d.cursor + 3'd1;
            end
            KEY_LEFT: begin
               if (d.cursor > CURSOR_HOUR_TENS) d.cursor = d.cursor - 3'd1;
            end
            default: begin
            end
         endcase
      end

      if (edit_en) begin
         case (d.cursor)
            CURSOR_HOUR_TENS:
               d.hour_tens = 2'(tens_step({1'b0, d.hour_tens}, {1'b0, HOUR_TENS_MAX}, raise));
            CURSOR_HOUR_UNITS:   d.hour_units   = units_step(d.hour_units, raise);
            CURSOR_MINUTE_TENS:  d.minute_tens  = tens_step(d.minute_tens, SIXTY_TENS_MAX, raise);
            CURSOR_MINUTE_UNITS: d.minute_units = units_step(d.minute_units, raise);
            CURSOR_SECOND_TENS:  d.second_tens  = tens_step(d.second_tens, SIXTY_TENS_MAX, raise);
            CURSOR_SECOND_UNITS: d.second_units = units_step(d.second_units, raise);
            default: begin
            end
         endcase
      end

      // Seconds roll into minutes, minutes into hours.
      if (second_tick) begin
         if (d.second_units != UNITS_MAX) begin
            d.second_units = d.second_units + 4'd1;
         end else begin
            d.second_units = 4'd0;
            if (d.second_tens != SIXTY_TENS_MAX) begin
               d.second_tens = d.second_tens + 3'd1;
            end else begin
               d.second_tens = 3'd0;
               if (d.minute_units != UNITS_MAX) begin
                  d.minute_units = d.minute_units + 4'd1;
               end else begin
                  d.minute_units = 4'd0;
                  if (d.minute_tens != SIXTY_TENS_MAX) begin
                     d.minute_tens = d.minute_tens + 3'd1;
                  end else begin
                     d.minute_tens = 3'd0;
                     if (d.hour_tens == HOUR_TENS_LAST && d.hour_units == HOUR_UNITS_LAST) begin
                        d.hour_tens  = 2'd0;
                        d.hour_units = 4'd0;
                     end else if (d.hour_units != UNITS_MAX) begin
                        d.hour_units = d.hour_units + 4'd1;
                     end else begin
                        d.hour_units = 4'd0;
                        d.hour_tens  = d.hour_tens + 2'd1;
                     end
                  end
               end
            end
         end
      end

      // Hour editing can leave an hour of 24 to 29; such an hour reads as midnight.
      if (d.hour_tens == HOUR_TENS_MAX && d.hour_units >= HOUR_UNITS_WRAP) begin
         d.hour_tens  = 2'd0;
         d.hour_units = 4'd0;
      end

      state_nxt.disp = d;
   end

endmodule

// ===== rtl/settable_digital_clock.sv =====
// Top level of the settable digital clock: request and response registers,
// clock state and configuration register. Depends on sdc_pkg, sdc_req_if,
// sdc_rsp_if and sdc_step.
//
// Usage. Each request on the req channel is either a timer tick (kind 0) or
// a raw active-low key byte (kind 1). Ticks drive a prescaler; every
// ticks_per_second ticks the time advances one second, carrying into minutes
// and hours, with hours wrapping at 24. The mode key toggles edit mode, in
// which the arrow keys move a cursor over the six digits and raise or lower
// the digit under it. Every request yields exactly one response on the rsp
// channel: six BCD digits, the edit mode and the cursor after the update.
// A request accepted on the req channel is first held in the request register;
// its update is then written into the response register, from which the
// response is valid on the rsp channel. Throughput is one request per cycle
// while the response register can drain; the whole update is a short carry
// chain and compare between the request register and the response register.
// When the receiver stalls, the response register holds and the request
// register fills; req.ready drops only once both are full.
// Reset clears the time, edit mode, cursor and prescaler, and loads 16 into
// ticks_per_second. The csr port writes ticks_per_second; the user must write
// it only while the block is idle, and the block itself does not enforce this.
module settable_digital_clock (
   input  logic        clock,
   input  logic        reset,
   sdc_req_if.sink     req,
   sdc_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import sdc_pkg::*;

   // Request stage.
   logic            in_valid_ff, in_valid_in;
   request_type     in_req_ff, in_req_in;
   // Response stage.
   logic            out_valid_ff, out_valid_in;
   display_type     out_disp_ff, out_disp_in;
   // Clock state and configuration.
   clock_state_type state_ff, state_in;
   logic [7:0]      tps_ff, tps_in;

   clock_state_type state_nxt;
   logic            out_free;
   logic            advance;
   logic            req_fire;

   sdc_step u_step (
      .state_cur        (state_ff),
      .req_item         (in_req_ff),
      .ticks_per_second (tps_ff),
      .state_nxt        (state_nxt)
   );

   // The response register can take a new result when empty or being drained.
   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_req_in    = in_req_ff;
      out_valid_in = out_valid_ff;
      out_disp_in  = out_disp_ff;
      state_in     = state_ff;
      tps_in       = csr_wr_en ? csr_wr_data : tps_ff;

      if (req_fire) begin
         in_valid_in       = 1'b1;
         in_req_in.kind     = req.kind;
         in_req_in.key_code = req.key_code;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      if (advance) begin
         state_in     = state_nxt;
         out_disp_in  = state_nxt.disp;
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         tps_ff       <= TPS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         tps_ff       <= tps_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_req_ff   <= in_req_in;
      out_disp_ff <= out_disp_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.hour_tens    = out_disp_ff.hour_tens;
   assign rsp.hour_units   = out_disp_ff.hour_units;
   assign rsp.minute_tens  = out_disp_ff.minute_tens;
   assign rsp.minute_units = out_disp_ff.minute_units;
   assign rsp.second_tens  = out_disp_ff.second_tens;
   assign rsp.second_units = out_disp_ff.second_units;
   assign rsp.edit_mode    = out_disp_ff.editing;
   assign rsp.cursor       = out_disp_ff.cursor;

endmodule

// ===== tb/tb_settable_digital_clock.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the settable digital clock: directed and random
// tick and key requests, checked against an in-bench clock predictor.
// Depends on sdc_pkg, sdc_req_if, sdc_rsp_if and settable_digital_clock.
module tb_settable_digital_clock;
   import sdc_pkg::*;

   // Time spans used by the digit editor and the carry chain.
   localparam int SIXTY_SPAN    = 60;
   localparam int HOUR_SPAN     = 30;
   localparam int HOURS_PER_DAY = 24;

   // Random part: requests per rate setting, and the receiver squeeze length.
   localparam int PHASE_REQUESTS = 280;
   localparam int SQUEEZE_CYCLES = 64;
   // Cycles without any handshake before the run is declared hung. The longest
   // legal quiet stretch is the squeeze plus the time taken by register writes.
   localparam int STALL_LIMIT    = 2000;

   // The predictor and checker. It keeps its own copy of the clock state and
   // of the ticks-per-second register, and a queue of displays still owed by
   // the block, one per accepted request.
   class display_checker;
      display_type expected_displays[$];
      logic [7:0]  ticks_per_second;
      logic [7:0]  prescale;
      int          seconds;
      int          minutes;
      int          hours;
      bit          editing;
      logic [2:0]  cursor;
      int unsigned mismatches;
      int unsigned compared;
      int unsigned ticks;
      int unsigned keys;

      function new();
         ticks_per_second = TPS_RESET;
         prescale         = '0;
         seconds          = 0;
         minutes          = 0;
         hours            = 0;
         editing          = 1'b0;
         cursor           = CURSOR_HOUR_TENS;
         mismatches       = 0;
         compared         = 0;
         ticks            = 0;
         keys             = 0;
      endfunction

      function void set_rate(logic [7:0] rate);
         ticks_per_second = rate;
      endfunction

      function int pending();
         return expected_displays.size();
      endfunction

      // Tens digit: steps by ten and wraps within the span of the field.
      function int tens_step(int value, int span, bit raise);
         if (raise) begin
            value += 10;
            if (value >= span) value -= span;
         end else if (value >= 10) begin
            value -= 10;
         end else begin
            value += span - 10;
         end
         return value;
      endfunction

      // Units digit: wraps within its decade in both directions.
      function int units_step(int value, bit raise);
         if (raise) begin
            value++;
            if (value % 10 == 0) value -= 10;
         end else if (value % 10 == 0) begin
            value += 9;
         end else begin
            value--;
         end
         return value;
      endfunction

      function void edit_digit(bit raise);
         case (cursor)
            CURSOR_HOUR_TENS:    hours   = tens_step(hours, HOUR_SPAN, raise);
            CURSOR_HOUR_UNITS:   hours   = units_step(hours, raise);
            CURSOR_MINUTE_TENS:  minutes = tens_step(minutes, SIXTY_SPAN, raise);
            CURSOR_MINUTE_UNITS: minutes = units_step(minutes, raise);
            CURSOR_SECOND_TENS:  seconds = tens_step(seconds, SIXTY_SPAN, raise);
            CURSOR_SECOND_UNITS: seconds = units_step(seconds, raise);
            default: ;
         endcase
      endfunction

      // Applies one accepted request and queues the display it must produce.
      function void note_request(request_type item);
         display_type want;
         if (item.kind == KIND_TICK) begin
            ticks++;
            prescale = prescale + 8'd1;
            if (prescale >= ticks_per_second) begin
               prescale = '0;
               seconds++;
            end
         end else begin
            keys++;
            if (item.key_code == KEY_MODE) begin
               editing = !editing;
            end else if (editing) begin
               case (item.key_code)
                  KEY_DOWN:  edit_digit(1'b0);
                  KEY_UP:    edit_digit(1'b1);
                  KEY_RIGHT: if (cursor < CURSOR_SECOND_UNITS) cursor++;
                  KEY_LEFT:  if (cursor > CURSOR_HOUR_TENS) cursor--;
                  default: ;
               endcase
            end
         end
         if (seconds >= SIXTY_SPAN) begin
            seconds = 0;
            minutes++;
         end
         if (minutes >= SIXTY_SPAN) begin
            minutes = 0;
            hours++;
         end
         if (hours >= HOURS_PER_DAY) hours = 0;

         want.hour_tens    = 2'(hours / 10);
         want.hour_units   = 4'(hours % 10);
         want.minute_tens  = 3'(minutes / 10);
         want.minute_units = 4'(minutes % 10);
         want.second_tens  = 3'(seconds / 10);
         want.second_units = 4'(seconds % 10);
         want.editing      = editing;
         want.cursor       = cursor;
         expected_displays.push_back(want);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_display(display_type got);
         display_type want;
         if (expected_displays.size() == 0) begin
            $error("display arrived with no request outstanding");
            mismatches++;
            return;
         end
         want = expected_displays.pop_front();
         compared++;
         compare_field("hour_tens", 8'(want.hour_tens), 8'(got.hour_tens));
         compare_field("hour_units", 8'(want.hour_units), 8'(got.hour_units));
         compare_field("minute_tens", 8'(want.minute_tens), 8'(got.minute_tens));
         compare_field("minute_units", 8'(want.minute_units), 8'(got.minute_units));
         compare_field("second_tens", 8'(want.second_tens), 8'(got.second_tens));
         compare_field("second_units", 8'(want.second_units), 8'(got.second_units));
         compare_field("edit_mode", 8'(want.editing), 8'(got.editing));
         compare_field("cursor", 8'(want.cursor), 8'(got.cursor));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   // Set by the request driver, cleared by the receiver once it starts a
   // long hold-off of its own.
   bit          squeeze_receiver = 1'b0;
   int unsigned stall_cycles     = 0;
   int unsigned rate_settings    = 1;

   display_checker board = new();

   sdc_req_if req_ch ();
   sdc_rsp_if rsp_ch ();

   settable_digital_clock u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offers one request and holds it until the block takes it. The request
   // is handed to the predictor at the edge where it is accepted, so the
   // expected displays stay in acceptance order.
   task automatic push_request(input logic kind, input logic [7:0] code);
      request_type item;
      req_ch.valid    <= 1'b1;
      req_ch.kind     <= kind;
      req_ch.key_code <= code;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      item.kind     = kind;
      item.key_code = code;
      board.note_request(item);
   endtask

   task automatic push_key(input logic [7:0] code);
      push_request(KIND_KEY, code);
   endtask

   // The key byte of a tick is ignored by the block, so it carries noise.
   task automatic push_tick();
      push_request(KIND_TICK, 8'($urandom));
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stops offering requests until every owed display has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Writes ticks_per_second with the block idle. Every request yields a
   // display, so an empty queue means the block has nothing in flight.
   task automatic write_rate(input logic [7:0] rate);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rate;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_rate(rate);
      rate_settings++;
   endtask

   // Mostly well-formed use: ticks and editing keys. Outside edit mode the
   // mode key is favored so that most keys land while editing. About one
   // request in ten is a random key byte, which the block must ignore
   // unless it happens to be a real key.
   task automatic random_request();
      int         roll;
      logic [7:0] noise;
      roll  = $urandom_range(0, 99);
      noise = 8'($urandom);
      if (roll < 45) begin
         push_request(KIND_TICK, noise);
      end else if (roll < (board.editing ? 49 : 70)) begin
         push_key(KEY_MODE);
      end else if (roll < 90) begin
         case ($urandom_range(0, 3))
            0:       push_key(KEY_DOWN);
            1:       push_key(KEY_UP);
            2:       push_key(KEY_RIGHT);
            default: push_key(KEY_LEFT);
         endcase
      end else begin
         push_key(noise);
      end
   endtask

   // One random phase at the current rate. The sender works in bursts with
   // short random gaps, some bursts run straight into the next. At the start
   // the receiver is asked to hold off for a long stretch, so the block backs
   // up and stalls its input. Halfway through the sender waits for every
   // owed display before going on.
   task automatic run_random_phase(input int count);
      int sent;
      int burst;
      bit drained;
      sent             = 0;
      drained          = 1'b0;
      squeeze_receiver = 1'b1;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < count; i++) begin
            random_request();
            sent++;
         end
         if (!drained && sent >= count / 2) begin
            drain_results();
            drained = 1'b1;
         end else if ($urandom_range(0, 3) != 0) begin
            pause_sender($urandom_range(1, 6));
         end
      end
   endtask

   // Request driver: reset, directed sequence, then random phases over a
   // range of ticks_per_second settings.
   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.kind     <= KIND_TICK;
      req_ch.key_code <= '0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset rate of 16. Keys other than the mode key
      // and unknown bytes are ignored outside edit mode.
      push_tick();
      push_key(KEY_DOWN);
      push_key(8'h00);
      push_key(KEY_MODE);
      // The cursor saturates at hour tens; lowering hour tens from 0 wraps
      // to 20.
      push_key(KEY_LEFT);
      push_key(KEY_DOWN);
      // Lowering the hour units from 20 wraps within the decade to 29, an
      // hour past the end of the day, which must be forced back to 0.
      push_key(KEY_RIGHT);
      push_key(KEY_DOWN);
      // Dial in 23:59:59 for the rollover below.
      push_key(KEY_LEFT);
      push_key(KEY_DOWN);
      push_key(KEY_RIGHT);
      push_key(KEY_UP);
      push_key(KEY_UP);
      push_key(KEY_UP);
      push_key(KEY_RIGHT);
      push_key(KEY_DOWN);
      push_key(KEY_RIGHT);
      push_key(KEY_DOWN);
      push_key(KEY_RIGHT);
      push_key(KEY_DOWN);
      push_key(KEY_RIGHT);
      push_key(KEY_DOWN);
      // The cursor saturates at second units; time keeps running in edit mode.
      push_key(KEY_RIGHT);
      push_tick();

      // The prescaler now stands above a rate of 1, so the next tick must
      // advance the seconds, carrying all the way round to midnight.
      write_rate(8'd1);
      push_tick();
      // With a rate of 0 every tick advances the seconds.
      write_rate(8'd0);
      push_tick();
      push_tick();

      write_rate(8'd255);
      run_random_phase(PHASE_REQUESTS);
      write_rate(8'd1);
      run_random_phase(PHASE_REQUESTS);
      write_rate(8'($urandom_range(1, 255)));
      run_random_phase(PHASE_REQUESTS);
      write_rate(8'd2);
      run_random_phase(PHASE_REQUESTS);
      write_rate(8'($urandom_range(1, 255)));
      run_random_phase(PHASE_REQUESTS);
      write_rate(8'd128);
      run_random_phase(PHASE_REQUESTS);

      // Everything is sent: let the last displays come back, then let the
      // two-register pipeline run on idle so that any stray output shows.
      drain_results();
      repeat (4) @(posedge clock);

      if (board.pending() != 0) begin
         $error("%0d displays never arrived", board.pending());
         board.mismatches++;
      end
      $display("Sent %0d requests (%0d ticks, %0d key presses) across %0d rate settings.",
               board.ticks + board.keys, board.ticks, board.keys, rate_settings);
      $display("Compared %0d displays, %0d field mismatches.",
               board.compared, board.mismatches);
      if (board.mismatches == 0) begin
         $display("tb_settable_digital_clock passed");
      end else begin
         $display("tb_settable_digital_clock failed");
      end
      $finish;
   end

   // Response receiver: stalls on patterns of its own, each held for a
   // random number of cycles. Styles run from always ready to mostly
   // stalled. When the driver asks for a squeeze, ready stays low for a long
   // count so that both internal registers fill and req.ready drops.
   initial begin
      int seg_len;
      int style;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         seg_len = $urandom_range(8, 120);
         style   = $urandom_range(0, 3);
         for (int i = 0; i < seg_len; i++) begin
            if (squeeze_receiver) begin
               squeeze_receiver = 1'b0;
               rsp_ch.ready <= 1'b0;
               repeat (SQUEEZE_CYCLES) @(posedge clock);
            end
            case (style)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= (i % 4 != 3);
            endcase
            @(posedge clock);
         end
      end
   end

   // Response monitor: every accepted display is checked against the oldest
   // owed one. Values read at the edge are those from before it.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_display({rsp_ch.hour_tens, rsp_ch.hour_units,
                              rsp_ch.minute_tens, rsp_ch.minute_units,
                              rsp_ch.second_tens, rsp_ch.second_units,
                              rsp_ch.edit_mode, rsp_ch.cursor});
      end
   end

   // Watchdog: counts edges at which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Timed out after %0d cycles without a handshake.", stall_cycles);
            $display("tb_settable_digital_clock failed");
            $finish;
         end
      end
   end

endmodule
